@@ hw/rtl/akpq_pkg.sv @@
// Shared constants, codes and the configuration register list of the keypad press qualifier.
`timescale 1ns / 1ps

package akpq_pkg;

   // Keypad ladder geometry. STEP_WIDTH is a power of two, so the rounding divide is a shift.
   localparam int STEP_WIDTH  = 64;
   localparam int MAP_ENTRIES = 16;
   localparam int ADC_BITS    = 12;

   localparam int LEVEL_W     = 12;
   localparam int CODE_W      = 3;
   localparam int COUNT_W     = 8;
   localparam int MAP_W       = 48;
   localparam int CSR_ADDR_W  = 3;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 8;

   localparam int STEP_SHIFT  = $clog2(STEP_WIDTH);
   localparam int IDX_W       = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

   // Key codes.
   localparam logic [CODE_W-1:0] KEY_NONE = 3'd0;
   localparam logic [CODE_W-1:0] KEY_MENU = 3'd1;
   localparam logic [CODE_W-1:0] KEY_DOWN = 3'd2;
   localparam logic [CODE_W-1:0] KEY_LONG = 3'd7;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_MAP       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRESS_COUNT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPEAT_COUNT  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG_COUNT    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_AUTOREPEAT_EN = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [MAP_W-1:0]   KEY_MAP_RST      = '0;
   localparam logic [COUNT_W-1:0] PRESS_COUNT_RST  = 8'd2;
   localparam logic [COUNT_W-1:0] REPEAT_COUNT_RST = 8'd20;
   localparam logic [COUNT_W-1:0] LONG_COUNT_RST   = 8'd60;

   typedef struct packed {
      logic [LEVEL_W-1:0] adc_level;
      logic               menu_open;
      logic               boot_mode;
   } req_item_type;

   typedef struct packed {
      logic              key_valid;
      logic [CODE_W-1:0] key_code;
      logic              polarity_toggle;
   } rsp_item_type;

endpackage

@@ hw/rtl/adc_keypad_press_qualifier.sv @@
// Top level of the resistor-ladder keypad press qualifier.
//
//   Channel  | Direction | Contents (lowest bit first)
//   req_     | in        | tdata: adc_level[11:0], menu_open, boot_mode, two zero bits
//   rsp_     | out       | tdata: key_valid, key_code[2:0], polarity_toggle, three zero bits
//   csr_     | in        | csr_we, csr_addr (register index), csr_wdata (48 bits)
//
// Each request yields exactly one response, through an input register and a result register;
// the decode, lookup and hold counter update sit between them, so one request per cycle is
// sustained while responses are taken. Synchronous reset clears the counter, the remembered
// key and both valid flags, and loads the configuration defaults. A stalled response holds the
// result register, and the input register keeps taking requests until it too is full.
`timescale 1ns / 1ps

module adc_keypad_press_qualifier (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // adc_level[11:0], menu_open[12], boot_mode[13], zero fill[15:14]
   input  logic [akpq_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // key_valid[0], key_code[3:1], polarity_toggle[4], zero fill[7:5]
   output logic [akpq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [akpq_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [akpq_pkg::MAP_W-1:0]       csr_wdata
);
   import akpq_pkg::*;

   localparam logic [LEVEL_W-1:0] LEVEL_MASK =
      (ADC_BITS >= LEVEL_W) ? {LEVEL_W{1'b1}} : LEVEL_W'((1 << ADC_BITS) - 1);
   localparam int SUM_W = LEVEL_W - 1;
   localparam int RAW_IDX_W = SUM_W - STEP_SHIFT;
   localparam logic [SUM_W-1:0] HALF_STEP = SUM_W'(STEP_WIDTH / 2);
   localparam logic [RAW_IDX_W-1:0] LAST_ENTRY = RAW_IDX_W'(MAP_ENTRIES - 1);

   // Configuration registers.
   logic [MAP_W-1:0]   key_map_ff;
   logic [COUNT_W-1:0] press_count_ff;
   logic [COUNT_W-1:0] repeat_count_ff;
   logic [COUNT_W-1:0] long_count_ff;
   logic               autorepeat_en_ff;

   // Input register.
   logic         in_valid_ff;
   req_item_type in_item_ff;

   // Result register.
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;

   // Press state.
   logic [COUNT_W-1:0] hold_ff;
   logic [COUNT_W-1:0] hold_in;
   logic [CODE_W-1:0]  remembered_ff;
   logic [CODE_W-1:0]  remembered_in;

   logic               out_load;
   logic [LEVEL_W-1:0] level;
   logic [SUM_W-1:0]   rounded;
   logic [RAW_IDX_W-1:0] raw_idx;
   logic [IDX_W-1:0]   idx;
   logic [CODE_W-1:0]  code;
   logic [COUNT_W-1:0] long_m1;
   logic [COUNT_W-1:0] hold_base;
   logic               valid;
   logic [CODE_W-1:0]  report;
   logic               toggle;

   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_item_ff.polarity_toggle, out_item_ff.key_code,
                        out_item_ff.key_valid};

   // Round the quarter level to the nearest ladder step and clamp to the map.
   always_comb begin
      level   = in_item_ff.adc_level & LEVEL_MASK;
      rounded = SUM_W'(level >> 2) + HALF_STEP;
      raw_idx = RAW_IDX_W'(rounded >> STEP_SHIFT);
      if (raw_idx >= LAST_ENTRY) begin
         idx = IDX_W'(LAST_ENTRY);
      end else begin
         idx = IDX_W'(raw_idx);
      end
      code = key_map_ff[CODE_W * idx +: CODE_W];
   end

   always_comb begin
      long_m1       = long_count_ff - 8'd1;
      valid         = 1'b0;
      report        = KEY_NONE;
      toggle        = 1'b0;
      remembered_in = remembered_ff;
      hold_base     = hold_ff;
      hold_in       = hold_ff;
      if (code == KEY_NONE) begin
         hold_in = '0;
         if (remembered_ff == KEY_MENU) begin
            valid         = 1'b1;
            report        = KEY_MENU;
            remembered_in = KEY_NONE;
         end
      end else begin
         if (hold_ff == press_count_ff) begin
            if (!in_item_ff.boot_mode) begin
               remembered_in = code;
            end
            if (in_item_ff.boot_mode || code != KEY_MENU) begin
               valid  = 1'b1;
               report = code;
            end
         end
         // Repeat and long handling override a press reported in the same request.
         if (hold_ff >= repeat_count_ff) begin
            if (code != KEY_MENU) begin
               if (in_item_ff.menu_open) begin
                  hold_base = press_count_ff;
                  if (autorepeat_en_ff) begin
                     remembered_in = code;
                     valid         = 1'b1;
                     report        = code;
                  end
               end else if (code == KEY_DOWN && hold_ff == long_m1) begin
                  toggle = 1'b1;
               end
            end else if (hold_ff == long_m1) begin
               remembered_in = KEY_LONG;
               valid         = 1'b1;
               report        = KEY_LONG;
            end
         end
         if (hold_base < long_count_ff) begin
            hold_in = hold_base + 8'd1;
         end else begin
            hold_in = hold_base;
         end
      end
      out_item_in.key_valid       = valid;
      out_item_in.key_code        = valid ? report : KEY_NONE;
      out_item_in.polarity_toggle = toggle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_map_ff       <= KEY_MAP_RST;
         press_count_ff   <= PRESS_COUNT_RST;
         repeat_count_ff  <= REPEAT_COUNT_RST;
         long_count_ff    <= LONG_COUNT_RST;
         autorepeat_en_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_KEY_MAP:       key_map_ff       <= csr_wdata;
            CSR_PRESS_COUNT:   press_count_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_REPEAT_COUNT:  repeat_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_LONG_COUNT:    long_count_ff    <= csr_wdata[COUNT_W-1:0];
            CSR_AUTOREPEAT_EN: autorepeat_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         hold_ff       <= '0;
         remembered_ff <= KEY_NONE;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_load) begin
            out_valid_ff  <= 1'b1;
            hold_ff       <= hold_in;
            remembered_ff <= remembered_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.adc_level <= req_tdata[LEVEL_W-1:0];
         in_item_ff.menu_open <= req_tdata[LEVEL_W];
         in_item_ff.boot_mode <= req_tdata[LEVEL_W+1];
      end
      if (out_load) begin
         out_item_ff <= out_item_in;
      end
   end

endmodule

@@ hw/rtl/akpq_checker.sv @@
// Port-level checker for the keypad press qualifier, bound to the top level.
`timescale 1ns / 1ps

module akpq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [akpq_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import akpq_pkg::*;

   // Requests accepted but not yet delivered as responses.
   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A response never appears without a request behind it.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 2'd0))
      else $error("response without an outstanding request");

   // Only the input and result registers can hold requests.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two requests in flight");

   // Without a reported key the code field reads as no key.
   a_code_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[3:1] == KEY_NONE))
      else $error("key code set on a response without a key");

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind adc_keypad_press_qualifier akpq_checker u_akpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
